// ===== sv/ojtb_pkg.sv =====
// Package for the one-shot job timer bank: word types, codes and the
// control and event structs passed between the controller and the cells.
// No dependencies.
package ojtb_pkg;

  // Action codes carried in a command word.
  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // Command word.
  typedef struct packed {
    logic        action;
    logic [31:0] delay_ticks;
    logic [7:0]  job_tag;
    logic        notify;
  } cmd_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0] kind;
    logic       accepted;
    logic [4:0] slot;
    logic [7:0] tag_out;
    logic       last;
  } rsp_word_t;

  // Controls broadcast from the controller to every cell.
  typedef struct packed {
    logic create;
    logic tick;
    logic shift;
  } cell_ctrl_t;

  // Pending expiry event that travels down the chain toward cell zero.
  typedef struct packed {
    logic       valid;
    logic [7:0] tag;
  } ev_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } st_t;

endpackage

// ===== sv/one_shot_job_timer_bank_unit.sv =====
// Top level of the one-shot job timer bank: controller, result register and
// a chain of SLOTS cells. Depends on ojtb_pkg and ojtb_cell.
//
//   channel | handshake            | word
//   cmd     | cmd_valid, cmd_ready | ojtb_pkg::cmd_word_t
//   rsp     | rsp_valid, rsp_ready | ojtb_pkg::rsp_word_t
//
// A create word is answered from the result register in the next cycle; the
// free-slot claim ripples through the cells. A tick decrements every busy count
// when accepted and loads the event stages; then they shift toward cell zero,
// one slot per scan step until all are read; a last step writes the done word.
// Every scan step waits while the result register is full and not taken.
// Reset clears all counts, notify flags and pending events; no clearing pass.
module one_shot_job_timer_bank_unit #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ojtb_pkg::cmd_word_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ojtb_pkg::rsp_word_t rsp
);
  import ojtb_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  st_t         state, state_next;
  logic [CW-1:0] scan_cnt, scan_cnt_next;
  logic        out_valid, out_valid_next;
  rsp_word_t   out_word, out_word_next;
  logic        out_free;
  logic        cmd_take;
  cell_ctrl_t  ctrl;
  logic [SLOTS:0] claim;
  logic [SLOTS-1:0] take_vec;
  ev_t         ev_chain [SLOTS+1];
  logic [4:0]  take_slot;

  assign out_free  = !out_valid || rsp_ready;
  assign cmd_ready = (state == ST_IDLE) && (out_free || (cmd.action == ACT_TICK));
  assign cmd_take  = cmd_valid && cmd_ready;
  assign rsp_valid = out_valid;
  assign rsp       = out_word;

  // Cell chain: claim ripples up, events shift down toward cell zero.
  assign claim[0]        = 1'b1;
  assign ev_chain[SLOTS] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ojtb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .delay_ticks (cmd.delay_ticks),
      .job_tag     (cmd.job_tag),
      .notify      (cmd.notify),
      .claim_in    (claim[i]),
      .claim_out   (claim[i+1]),
      .take        (take_vec[i]),
      .ev_in       (ev_chain[i+1]),
      .ev_out      (ev_chain[i])
    );
  end

  // Encode the one-hot take vector into a slot number.
  always_comb begin
    take_slot = 5'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (take_vec[i]) begin
        take_slot = take_slot | 5'(i);
      end
    end
  end

  // Controller state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_word_next;
  end

  // Next state, cell controls and the next result word.
  always_comb begin
    state_next     = state;
    scan_cnt_next  = scan_cnt;
    out_valid_next = out_valid && !rsp_ready;
    out_word_next  = out_word;
    ctrl           = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          if (cmd.action == ACT_CREATE) begin
            ctrl.create            = 1'b1;
            out_valid_next         = 1'b1;
            out_word_next          = '0;
            out_word_next.kind     = KIND_CREATE;
            out_word_next.accepted = !claim[SLOTS];
            out_word_next.slot     = take_slot;
            out_word_next.last     = 1'b1;
          end else begin
            ctrl.tick     = 1'b1;
            scan_cnt_next = '0;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (scan_cnt == CW'(SLOTS)) begin
            out_valid_next     = 1'b1;
            out_word_next      = '0;
            out_word_next.kind = KIND_DONE;
            out_word_next.last = 1'b1;
            state_next         = ST_IDLE;
          end else begin
            ctrl.shift    = 1'b1;
            scan_cnt_next = scan_cnt + CW'(1);
            if (ev_chain[0].valid) begin
              out_valid_next        = 1'b1;
              out_word_next         = '0;
              out_word_next.kind    = KIND_EXPIRY;
              out_word_next.slot    = 5'(scan_cnt);
              out_word_next.tag_out = ev_chain[0].tag;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ojtb_cell.sv =====
// One slot of the timer bank: count, tag, notify flag and an event stage.
// Depends on ojtb_pkg.
module ojtb_cell (
  input  logic              clk,
  input  logic              rst,
  input  ojtb_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]       delay_ticks,
  input  logic [7:0]        job_tag,
  input  logic              notify,
  input  logic              claim_in,
  output logic              claim_out,
  output logic              take,
  input  ojtb_pkg::ev_t     ev_in,
  output ojtb_pkg::ev_t     ev_out
);
  import ojtb_pkg::*;

  logic [31:0] remaining;
  logic [7:0]  slot_tag;
  logic        slot_notify;
  logic        ev_valid;
  logic [7:0]  ev_tag;
  logic        busy;

  // A free slot takes the claim; a busy one passes it to its neighbor.
  assign busy      = (remaining != 32'd0);
  assign take      = ctrl.create && claim_in && !busy;
  assign claim_out = claim_in && busy;
  assign ev_out    = '{valid: ev_valid, tag: ev_tag};

  // Count and notify flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining   <= 32'd0;
      slot_notify <= 1'b0;
    end else if (take) begin
      remaining   <= delay_ticks;
      slot_notify <= notify;
    end else if (ctrl.tick && busy) begin
      remaining <= remaining - 32'd1;
    end
  end

  // The tag is written only by a create; a tick copies it into the event stage.
  always_ff @(posedge clk) begin
    if (take) begin
      slot_tag <= job_tag;
    end
  end

  // Event stage: loaded on a tick, then shifted one cell per scan step.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (ctrl.tick) begin
      ev_valid <= (remaining == 32'd1) && slot_notify;
    end else if (ctrl.shift) begin
      ev_valid <= ev_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      ev_tag <= slot_tag;
    end else if (ctrl.shift) begin
      ev_tag <= ev_in.tag;
    end
  end

endmodule

// ===== sim/ojtb_checker.sv =====
// Checker for the one-shot job timer bank: watches the command and result
// channels, predicts every result word and compares it field by field.
// Depends on ojtb_pkg.
module ojtb_checker #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_ready,
  input  ojtb_pkg::cmd_word_t cmd,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  ojtb_pkg::rsp_word_t rsp,
  output int                  fail_count,
  output int                  words_outstanding
);
  import ojtb_pkg::*;

  localparam int PRINT_CAP = 100;

  // Shadow copy of the bank and the result words still owed by the block.
  logic [31:0] ticks_left [SLOTS];
  logic [7:0]  shadow_tag [SLOTS];
  logic        shadow_notify [SLOTS];
  rsp_word_t   owed_words [$];

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] result mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  // Apply one accepted command word to the shadow bank and queue the
  // result words it causes.
  task automatic predict_bank_step(input cmd_word_t w);
    rsp_word_t r;
    bit        placed;
    placed = 1'b0;
    r      = '0;
    if (w.action == ACT_CREATE) begin
      // Lowest free slot wins; a full bank rejects with slot zero.
      r.kind = KIND_CREATE;
      r.last = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && ticks_left[i] == 32'd0) begin
          placed           = 1'b1;
          ticks_left[i]    = w.delay_ticks;
          shadow_tag[i]    = w.job_tag;
          shadow_notify[i] = w.notify;
          r.accepted       = 1'b1;
          r.slot           = 5'(i);
        end
      end
      owed_words.push_back(r);
    end else begin
      // Count down every busy slot; report the ones that run out with
      // notify set, in slot order, then close with the done word.
      for (int i = 0; i < SLOTS; i++) begin
        if (ticks_left[i] != 32'd0) begin
          ticks_left[i] = ticks_left[i] - 32'd1;
          if (ticks_left[i] == 32'd0 && shadow_notify[i]) begin
            r         = '0;
            r.kind    = KIND_EXPIRY;
            r.slot    = 5'(i);
            r.tag_out = shadow_tag[i];
            owed_words.push_back(r);
          end
        end
      end
      r      = '0;
      r.kind = KIND_DONE;
      r.last = 1'b1;
      owed_words.push_back(r);
    end
  endtask

  task automatic check_result(input rsp_word_t got);
    rsp_word_t want;
    if (owed_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind %0d slot %0d", got.kind, got.slot));
    end else begin
      want = owed_words.pop_front();
      compare_field("kind", int'(got.kind), int'(want.kind));
      compare_field("accepted", int'(got.accepted), int'(want.accepted));
      compare_field("slot", int'(got.slot), int'(want.slot));
      compare_field("tag_out", int'(got.tag_out), int'(want.tag_out));
      compare_field("last", int'(got.last), int'(want.last));
    end
  endtask

  // Sample both channels at the clock edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        ticks_left[i]    = 32'd0;
        shadow_tag[i]    = 8'd0;
        shadow_notify[i] = 1'b0;
      end
      owed_words.delete();
      words_outstanding <= 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        predict_bank_step(cmd);
      end
      if (rsp_valid && rsp_ready) begin
        check_result(rsp);
      end
      words_outstanding <= owed_words.size();
    end
  end

endmodule

// ===== sim/tb_one_shot_job_timer_bank_unit.sv =====
// Testbench top for the one-shot job timer bank: drives command words,
// takes result words with random stalls and gives the verdict.
// Depends on ojtb_pkg, one_shot_job_timer_bank_unit and ojtb_checker.
module tb_one_shot_job_timer_bank_unit;
  import ojtb_pkg::*;

  localparam int SLOTS         = 8;
  localparam int RANDOM_JOBS   = 160;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 3 * (SLOTS + 1) + 10;
  localparam int LONG_HOLD     = 250;
  localparam int HOLD_AT_WORD  = 60;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_word_t cmd       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  int fail_count;
  int words_outstanding;
  int cycle_count     = 0;
  int big_delays_left = 2;
  bit sender_burst    = 1'b0;

  always #5 clk = ~clk;

  one_shot_job_timer_bank_unit #(.SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  ojtb_checker #(.SLOTS(SLOTS)) u_checker (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .rsp               (rsp),
    .fail_count        (fail_count),
    .words_outstanding (words_outstanding)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic cmd_word_t job_word(logic [31:0] delay, logic [7:0] tag, logic ntf);
    cmd_word_t w;
    w.action      = ACT_CREATE;
    w.delay_ticks = delay;
    w.job_tag     = tag;
    w.notify      = ntf;
    return w;
  endfunction

  // Tick word; the other fields are don't-care and carry random junk.
  function automatic cmd_word_t tick_word();
    cmd_word_t w;
    w.action      = ACT_TICK;
    w.delay_ticks = $urandom;
    w.job_tag     = 8'($urandom);
    w.notify      = 1'($urandom);
    return w;
  endfunction

  function automatic int sender_gap();
    return sender_burst ? 0 : $urandom_range(0, 14);
  endfunction

  // Offer one word after a gap and hold it until the block takes it.
  // Valid is only lowered when a gap follows, so it never toggles in a step.
  task automatic send_word(input cmd_word_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result word has come back.
  task automatic drain_bank();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (words_outstanding != 0);
  endtask

  // Random mix: about half ticks, the rest creates with mostly short delays,
  // some zero delays and a couple of huge ones that hold a slot for good.
  task automatic random_word(output cmd_word_t w);
    int pick;
    logic [31:0] delay;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w = tick_word();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        delay = 32'd0;
      end else if (pick < 13 && big_delays_left > 0) begin
        delay = $urandom | 32'h8000_0000;
        big_delays_left--;
      end else begin
        delay = $urandom_range(1, 8);
      end
      w = job_word(delay, 8'($urandom), ($urandom_range(0, 4) != 0));
    end
  endtask

  // Result side: a random stall before each word, one long hold-off so the
  // block backs up into its input, and a stretch with no stalls at all.
  initial begin : rsp_side
    int wait_cycles;
    int taken;
    taken = 0;
    @(posedge clk);
    forever begin
      if (taken == HOLD_AT_WORD) begin
        wait_cycles = LONG_HOLD;
      end else if (taken >= 150 && taken < 220) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 14);
      end
      if (wait_cycles > 0) begin
        rsp_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  // Command side: reset, directed words, random words, then the verdict.
  initial begin : cmd_side
    cmd_word_t w;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Tick on an empty bank with every ignored field at ones.
    send_word('1);
    // Zero delay is accepted but leaves the slot free.
    send_word(job_word(32'd0, 8'hFF, 1'b1));
    send_word(job_word(32'd1, 8'hA5, 1'b1));
    // Silent expiry: notify clear.
    send_word(job_word(32'd1, 8'h5A, 1'b0));
    send_word(job_word(32'd2, 8'h00, 1'b1));
    send_word(tick_word());
    send_word(tick_word());

    // Fill the bank, get one rejection, then let all slots fire together.
    for (int n = 0; n < SLOTS; n++) begin
      send_word(job_word(32'd3, 8'(n * 37 + 11), 1'b1));
    end
    send_word(job_word(32'hFFFF_FFFF, 8'hFF, 1'b1));
    repeat (3) send_word(tick_word());
    send_word(job_word(32'd5, 8'h3C, 1'b0));

    drain_bank();

    for (int n = 0; n < RANDOM_JOBS; n++) begin
      if (n == 80) begin
        drain_bank();
      end
      sender_burst = (n >= 100 && n < 130);
      random_word(w);
      send_word(w);
    end

    drain_bank();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ojtb_pkg.sv
sv/ojtb_cell.sv
sv/one_shot_job_timer_bank_unit.sv
sim/ojtb_checker.sv
sim/tb_one_shot_job_timer_bank_unit.sv
